/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ralg_pkg.sv */
// Types, constants and the gamma table for the auto-level gamma pipeline
`timescale 1ns / 1ps

package ralg_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned TDATA_W    = PIX_W * NUM_CH;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned DIV_BITS   = PIX_W / DIV_STAGES;
  localparam int unsigned PIPE_DEPTH = DIV_STAGES + 2;
  localparam int unsigned LUT_DEPTH  = 1 << PIX_W;

  localparam logic [PIX_W-1:0] LOW_RESET  = '0;
  localparam logic [PIX_W-1:0] HIGH_RESET = '1;
  localparam logic [PIX_W-1:0] PIX_MAX    = '1;

  // Channel slots, lowest tdata byte first
  localparam int unsigned CH_BLUE  = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_RED   = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_RED_LOW    = 3'd0,
    CFG_RED_HIGH   = 3'd1,
    CFG_GREEN_LOW  = 3'd2,
    CFG_GREEN_HIGH = 3'd3,
    CFG_BLUE_LOW   = 3'd4,
    CFG_BLUE_HIGH  = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_DIV  = 2'd0,
    MODE_ZERO = 2'd1,
    MODE_MAX  = 2'd2
  } ch_mode_t;

  typedef struct packed {
    logic [NUM_CH-1:0][PIX_W-1:0] lo;
    logic [NUM_CH-1:0][PIX_W-1:0] hi;
  } thr_t;

  typedef struct packed {
    ch_mode_t         mode;
    logic [PIX_W:0]   rem;
    logic [PIX_W-1:0] den;
    logic [PIX_W-1:0] quo;
  } chan_t;

  typedef chan_t [NUM_CH-1:0] pix_t;

  typedef logic [LUT_DEPTH-1:0][PIX_W-1:0] lut_t;

  // Largest y with y^20 <= s^9 * 2^88, i.e. floor(256*(s/256)^0.45)
  function automatic logic [PIX_W-1:0] gamma_entry(int unsigned s);
    logic [167:0] rhs;
    logic [167:0] p;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    rhs = 168'd1;
    for (int i = 0; i < 9; i++) rhs = rhs * 168'(s);
    rhs = rhs << 88;
    lo = 0;
    hi = LUT_DEPTH - 1;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      p = 168'd1;
      for (int k = 0; k < 20; k++) p = p * 168'(mid);
      if (p <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[PIX_W-1:0];
  endfunction

  function automatic lut_t build_gamma_lut();
    lut_t t;
    for (int s = 0; s < LUT_DEPTH; s++) t[s] = gamma_entry(s);
    return t;
  endfunction

  localparam lut_t GAMMA_LUT = build_gamma_lut();

endpackage

/* rtl/ralg_prep.sv */
// Entry stage: classify each channel against its thresholds, set up the division
`timescale 1ns / 1ps

module ralg_prep (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ce,
  input  logic                          in_valid,
  input  logic [ralg_pkg::TDATA_W-1:0]  in_data,
  input  ralg_pkg::thr_t                thr,
  output logic                          valid_r,
  output ralg_pkg::pix_t                pix_r
);
  import ralg_pkg::*;

  pix_t pix_nxt;

  always_comb begin
    logic [PIX_W-1:0] x;
    for (int c = 0; c < NUM_CH; c++) begin
      x = in_data[c*PIX_W +: PIX_W];
      pix_nxt[c].rem = {1'b0, x - thr.lo[c]};
      pix_nxt[c].den = thr.hi[c] - thr.lo[c];
      pix_nxt[c].quo = '0;
      if (x <= thr.lo[c]) begin
        pix_nxt[c].mode = MODE_ZERO;
      end else if (x < thr.hi[c]) begin
        pix_nxt[c].mode = MODE_DIV;
      end else begin
        pix_nxt[c].mode = MODE_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ce) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce && in_valid) begin
      pix_r <= pix_nxt;
    end
  end

endmodule

/* rtl/ralg_div_stage.sv */
// One divider stage: restoring division steps for all three channels
`timescale 1ns / 1ps

module ralg_div_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           ce,
  input  logic           in_valid,
  input  ralg_pkg::pix_t in_pix,
  output logic           valid_r,
  output ralg_pkg::pix_t pix_r
);
  import ralg_pkg::*;

  pix_t pix_nxt;

  always_comb begin
    logic [PIX_W:0] r2;
    pix_nxt = in_pix;
    for (int c = 0; c < NUM_CH; c++) begin
      for (int b = 0; b < DIV_BITS; b++) begin
        r2 = {pix_nxt[c].rem[PIX_W-1:0], 1'b0};
        if (r2 >= {1'b0, pix_nxt[c].den}) begin
          pix_nxt[c].rem = r2 - {1'b0, pix_nxt[c].den};
          pix_nxt[c].quo = {pix_nxt[c].quo[PIX_W-2:0], 1'b1};
        end else begin
          pix_nxt[c].rem = r2;
          pix_nxt[c].quo = {pix_nxt[c].quo[PIX_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ce) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce && in_valid) begin
      pix_r <= pix_nxt;
    end
  end

endmodule

/* rtl/ralg_gamma.sv */
// Output stage: gamma table lookup and clamping into the output register
`timescale 1ns / 1ps

module ralg_gamma (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ce,
  input  logic                          in_valid,
  input  ralg_pkg::pix_t                in_pix,
  output logic                          valid_r,
  output logic [ralg_pkg::TDATA_W-1:0]  data_r
);
  import ralg_pkg::*;

  logic [TDATA_W-1:0] data_nxt;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      case (in_pix[c].mode)
        MODE_DIV:  data_nxt[c*PIX_W +: PIX_W] = GAMMA_LUT[in_pix[c].quo];
        MODE_ZERO: data_nxt[c*PIX_W +: PIX_W] = '0;
        MODE_MAX:  data_nxt[c*PIX_W +: PIX_W] = PIX_MAX;
        default:   data_nxt[c*PIX_W +: PIX_W] = PIX_MAX;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ce) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* rtl/rgb_auto_level_gamma.sv */
// Each pixel passes the prep, divider and gamma registers; each holds one pixel.
// Throughput: one pixel per clock unless out_tready stalls; bubbles collapse.
// The 8-bit quotient comes from 4 divider stages of 2 restoring steps each.
// Reset (rst_n low, synchronous) clears all stage valid bits and sets
// every low threshold to 0 and every high threshold to 255.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rgb_auto_level_gamma (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ralg_pkg::TDATA_W-1:0]   in_tdata,   // blue_in, green_in, red_in
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ralg_pkg::TDATA_W-1:0]   out_tdata,  // blue_out, green_out, red_out
  input  logic                           cfg_we,
  input  logic [ralg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ralg_pkg::PIX_W-1:0]     cfg_wdata
);
  import ralg_pkg::*;

  thr_t                  thr_r;
  logic [PIPE_DEPTH-1:0] stage_v;
  logic [PIPE_DEPTH-1:0] stage_ce;
  pix_t                  stage_pix [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CH; c++) begin
        thr_r.lo[c] <= LOW_RESET;
        thr_r.hi[c] <= HIGH_RESET;
      end
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_RED_LOW:    thr_r.lo[CH_RED]   <= cfg_wdata;
        CFG_RED_HIGH:   thr_r.hi[CH_RED]   <= cfg_wdata;
        CFG_GREEN_LOW:  thr_r.lo[CH_GREEN] <= cfg_wdata;
        CFG_GREEN_HIGH: thr_r.hi[CH_GREEN] <= cfg_wdata;
        CFG_BLUE_LOW:   thr_r.lo[CH_BLUE]  <= cfg_wdata;
        CFG_BLUE_HIGH:  thr_r.hi[CH_BLUE]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    stage_ce[PIPE_DEPTH-1] = !stage_v[PIPE_DEPTH-1] || out_tready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      stage_ce[k] = !stage_v[k] || stage_ce[k+1];
    end
  end

  assign in_tready  = stage_ce[0];
  assign out_tvalid = stage_v[PIPE_DEPTH-1];

  ralg_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (stage_ce[0]),
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .thr      (thr_r),
    .valid_r  (stage_v[0]),
    .pix_r    (stage_pix[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    ralg_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .ce       (stage_ce[g+1]),
      .in_valid (stage_v[g]),
      .in_pix   (stage_pix[g]),
      .valid_r  (stage_v[g+1]),
      .pix_r    (stage_pix[g+1])
    );
  end

  ralg_gamma u_gamma (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (stage_ce[PIPE_DEPTH-1]),
    .in_valid (stage_v[PIPE_DEPTH-2]),
    .in_pix   (stage_pix[DIV_STAGES]),
    .valid_r  (stage_v[PIPE_DEPTH-1]),
    .data_r   (out_tdata)
  );

  `ASSERT_IMP(a_stall_only_when_full, !in_tready, (stage_v == '1) && !out_tready, "input stalled with room in pipeline")
  `ASSERT_NEXT(a_transfer_enters, in_tvalid && in_tready, stage_v[0], "accepted pixel not held in entry stage")
  `ASSERT_IMP(a_rem_below_den, stage_v[0] && stage_pix[0][CH_RED].mode == MODE_DIV, stage_pix[0][CH_RED].rem < {1'b0, stage_pix[0][CH_RED].den}, "red dividend not below divisor")
  `ASSERT_NEXT(a_out_holds_when_blocked, out_tvalid && !out_tready, $stable(out_tdata) && (stage_v[PIPE_DEPTH-1] == 1'b1), "blocked result changed")

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the RGB auto-level gamma pipeline
`timescale 1ns / 1ps

module testbench;
  import ralg_pkg::*;

  typedef logic [NUM_CH-1:0][PIX_W-1:0] rgb_bytes_t;

  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_7 = 3'd7;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_PHASES = 12;
  localparam int PIXELS_PER_PHASE = 108;
  localparam int DRAIN_CYCLES = 12;

  class level_gamma_board;
    logic [PIX_W-1:0] lo [NUM_CH];
    logic [PIX_W-1:0] hi [NUM_CH];
    logic [PIX_W-1:0] gamma_rom [LUT_DEPTH];
    rgb_bytes_t corrected_q [$];
    int errors;
    int checked;

    function new();
      logic [191:0] target;
      logic [191:0] pw;
      int y;
      bit grow;
      y = 0;
      for (int s = 0; s < LUT_DEPTH; s++) begin
        target = 192'd1;
        for (int i = 0; i < 9; i++) target = target * 192'(s);
        target = target << 88;
        grow = 1'b1;
        while (grow && y < 255) begin
          pw = 192'd1;
          for (int k = 0; k < 20; k++) pw = pw * 192'(y + 1);
          if (pw <= target) y++;
          else grow = 1'b0;
        end
        gamma_rom[s] = y[PIX_W-1:0];
      end
      for (int c = 0; c < NUM_CH; c++) begin
        lo[c] = LOW_RESET;
        hi[c] = HIGH_RESET;
      end
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [PIX_W-1:0] v);
      case (idx)
        CFG_RED_LOW:    lo[CH_RED] = v;
        CFG_RED_HIGH:   hi[CH_RED] = v;
        CFG_GREEN_LOW:  lo[CH_GREEN] = v;
        CFG_GREEN_HIGH: hi[CH_GREEN] = v;
        CFG_BLUE_LOW:   lo[CH_BLUE] = v;
        CFG_BLUE_HIGH:  hi[CH_BLUE] = v;
        default: ;
      endcase
    endfunction

    function logic [PIX_W-1:0] level_channel(int c, logic [PIX_W-1:0] x);
      int unsigned q;
      if (x > lo[c] && x < hi[c]) begin
        q = (256 * (int'(x) - int'(lo[c]))) / (int'(hi[c]) - int'(lo[c]));
        return gamma_rom[q & 255];
      end else if (x <= lo[c]) begin
        return '0;
      end
      return PIX_MAX;
    endfunction

    function void note_pixel(rgb_bytes_t px);
      rgb_bytes_t want;
      for (int c = 0; c < NUM_CH; c++) want[c] = level_channel(c, px[c]);
      corrected_q.push_back(want);
    endfunction

    function void check_pixel(rgb_bytes_t got);
      string ch_name [NUM_CH];
      rgb_bytes_t want;
      ch_name[CH_BLUE] = "blue";
      ch_name[CH_GREEN] = "green";
      ch_name[CH_RED] = "red";
      if (corrected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = corrected_q.pop_front();
      checked++;
      for (int c = 0; c < NUM_CH; c++) begin
        if (got[c] !== want[c]) begin
          errors++;
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, ch_name[c],
                   want[c], got[c]);
        end
      end
    endfunction

    function int pending();
      return corrected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [TDATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [TDATA_W-1:0] out_tdata;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [PIX_W-1:0] cfg_wdata;

  level_gamma_board board;
  int gap_odds;
  int stall_odds;
  int stall_left;
  int cycles;
  int pixels_sent;
  int settings_applied;

  rgb_auto_level_gamma DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               board.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_pixel(out_tdata);
  end

  // back-pressure the result side in random bursts
  always @(negedge clk) begin
    if (!rst_n || stall_odds == 0) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(1, stall_odds) == 1) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [PIX_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    board.write_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic apply_levels(input rgb_bytes_t lo_v, input rgb_bytes_t hi_v,
                              input bit spare);
    while (board.pending() != 0) @(negedge clk);
    write_reg(CFG_RED_LOW, lo_v[CH_RED]);
    write_reg(CFG_RED_HIGH, hi_v[CH_RED]);
    write_reg(CFG_GREEN_LOW, lo_v[CH_GREEN]);
    write_reg(CFG_GREEN_HIGH, hi_v[CH_GREEN]);
    write_reg(CFG_BLUE_LOW, lo_v[CH_BLUE]);
    write_reg(CFG_BLUE_HIGH, hi_v[CH_BLUE]);
    if (spare) begin
      write_reg(CFG_SPARE_6, 8'($urandom_range(0, 255)));
      write_reg(CFG_SPARE_7, 8'($urandom_range(0, 255)));
    end
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  task automatic send_pixel(input rgb_bytes_t px);
    int gap;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      gap = $urandom_range(1, 14);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_pixel(px);
    pixels_sent++;
    @(negedge clk);
  endtask

  function automatic void pick_pair(output logic [PIX_W-1:0] lo_v,
                                    output logic [PIX_W-1:0] hi_v);
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    a = 8'($urandom_range(0, 255));
    b = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: begin lo_v = LOW_RESET; hi_v = HIGH_RESET; end
      1: begin lo_v = a; hi_v = a; end
      2: begin lo_v = (a > b) ? a : b; hi_v = (a > b) ? b : a; end
      3: begin lo_v = (a == PIX_MAX) ? a - 8'd1 : a; hi_v = lo_v + 8'd1; end
      4: begin lo_v = 8'($urandom_range(0, 40)); hi_v = 8'($urandom_range(215, 255)); end
      default: begin lo_v = (a < b) ? a : b; hi_v = (a < b) ? b : a; end
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] pick_level(logic [PIX_W-1:0] lo_v,
                                                  logic [PIX_W-1:0] hi_v);
    logic [PIX_W-1:0] off;
    off = 8'($urandom_range(0, 4));
    case ($urandom_range(0, 3))
      2: return lo_v + off - 8'd2;
      3: return hi_v + off - 8'd2;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    rgb_bytes_t lo_v;
    rgb_bytes_t hi_v;
    rgb_bytes_t px;
    logic [PIX_W-1:0] edge_vals [];
    board = new();
    cycles = 0;
    pixels_sent = 0;
    settings_applied = 0;
    gap_odds = 0;
    stall_odds = 0;
    stall_left = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset thresholds: full range
    edge_vals = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'hAA, 8'h55, 8'h80};
    foreach (edge_vals[i]) begin
      px[CH_BLUE] = edge_vals[i];
      px[CH_GREEN] = ~edge_vals[i];
      px[CH_RED] = edge_vals[i];
      send_pixel(px);
    end
    in_tvalid <= 1'b0;

    // ordinary, inverted and collapsed windows; spare indexes must not take effect
    lo_v[CH_RED] = 8'd50;  hi_v[CH_RED] = 8'd200;
    lo_v[CH_GREEN] = 8'd200; hi_v[CH_GREEN] = 8'd50;
    lo_v[CH_BLUE] = 8'd100; hi_v[CH_BLUE] = 8'd100;
    apply_levels(lo_v, hi_v, 1'b1);
    edge_vals = '{8'd49, 8'd50, 8'd51, 8'd199, 8'd200, 8'd201, 8'd99, 8'd100, 8'd101};
    foreach (edge_vals[i]) begin
      px = {NUM_CH{edge_vals[i]}};
      send_pixel(px);
    end
    in_tvalid <= 1'b0;

    // narrowest windows at both ends, and low equal to high at zero
    lo_v[CH_RED] = 8'd0;   hi_v[CH_RED] = 8'd1;
    lo_v[CH_GREEN] = 8'd254; hi_v[CH_GREEN] = 8'd255;
    lo_v[CH_BLUE] = 8'd0;  hi_v[CH_BLUE] = 8'd0;
    apply_levels(lo_v, hi_v, 1'b0);
    edge_vals = '{8'd0, 8'd1, 8'd254, 8'd255, 8'd128};
    foreach (edge_vals[i]) begin
      px = {NUM_CH{edge_vals[i]}};
      send_pixel(px);
    end
    in_tvalid <= 1'b0;

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      for (int c = 0; c < NUM_CH; c++) pick_pair(lo_v[c], hi_v[c]);
      if (ph == 0) begin
        lo_v = {NUM_CH{PIX_MAX}};
        hi_v = {NUM_CH{PIX_MAX}};
      end
      apply_levels(lo_v, hi_v, $urandom_range(0, 2) == 0);
      if (ph == RANDOM_PHASES - 1) begin
        gap_odds = 0;
        stall_odds = 0;
      end else begin
        gap_odds = $urandom_range(0, 2) * 3;
        stall_odds = $urandom_range(0, 2) * 4;
      end
      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        for (int c = 0; c < NUM_CH; c++) px[c] = pick_level(lo_v[c], hi_v[c]);
        send_pixel(px);
      end
      in_tvalid <= 1'b0;
    end

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d pixels across %0d threshold settings (inverted, equal and edge",
             pixels_sent, settings_applied);
    $display("windows included); %0d results checked", board.checked);
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
